// File: src/pcrb_pkg.sv
// Shared types and constants for the pulse capture ring buffer.
// No dependencies; every other file of the block depends on it.
`default_nettype none

package pcrb_pkg;

  localparam logic [1:0] OP_CAPTURE = 2'd0;
  localparam logic [1:0] OP_DRAIN   = 2'd1;
  localparam logic [1:0] OP_FLUSH   = 2'd2;

  localparam int unsigned DUR_W  = 16;
  localparam int unsigned RAW_W  = 32;
  localparam int unsigned REC_W  = DUR_W + 1;
  localparam logic [DUR_W-1:0] DURATION_CAP = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_DRAIN   = 2'd1,
    CMD_FLUSH   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             level;
    logic [DUR_W-1:0] duration;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic ring_empty;
  } back_status_t;

  function automatic logic [DUR_W-1:0] saturate_duration(input logic [RAW_W-1:0] raw);
    logic [DUR_W-1:0] res;
    res = (|raw[RAW_W-1:DUR_W]) ? DURATION_CAP : raw[DUR_W-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/pcrb_if.sv
// Request and result channel interfaces (valid/ready) of the pulse ring buffer.
// Depends on pcrb_pkg for field widths.
`default_nettype none

interface pcrb_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic                       pulse_level;
  logic [pcrb_pkg::RAW_W-1:0] pulse_duration;

  modport source (output valid, opcode, pulse_level, pulse_duration, input ready);
  modport sink   (input valid, opcode, pulse_level, pulse_duration, output ready);
endinterface

interface pcrb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       out_level;
  logic [pcrb_pkg::DUR_W-1:0] out_duration;
  logic                       last_of_burst;

  modport source (output valid, out_level, out_duration, last_of_burst, input ready);
  modport sink   (input valid, out_level, out_duration, last_of_burst, output ready);
endinterface

`default_nettype wire

// File: src/pcrb_front.sv
// Front end: takes requests, drops the no-op ones, queues commands (2 entries).
// Depends on pcrb_pkg and pcrb_req_if.
`default_nettype none

module pcrb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  pcrb_req_if.sink           req,
  output pcrb_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);
  import pcrb_pkg::*;

  cmd_t       q [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] count;

  cmd_t       cmd_new;
  logic       keep;
  logic       push;
  logic       pop;

  // zero-duration captures and the unused opcode never reach the back end
  always_comb begin
    cmd_new.level    = req.pulse_level;
    cmd_new.duration = saturate_duration(req.pulse_duration);
    keep             = 1'b0;
    cmd_new.kind     = CMD_CAPTURE;
    case (req.opcode)
      OP_CAPTURE: begin
        keep = |req.pulse_duration;
      end
      OP_DRAIN: begin
        keep         = 1'b1;
        cmd_new.kind = CMD_DRAIN;
      end
      OP_FLUSH: begin
        keep         = 1'b1;
        cmd_new.kind = CMD_FLUSH;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready && keep;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_idx] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_idx <= ~wr_idx;
      if (pop)  rd_idx <= ~rd_idx;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: src/pcrb_back.sv
// Back end: ring memory, pointers and drain sequencer with result register.
// Depends on pcrb_pkg and pcrb_rsp_if.
`default_nettype none

module pcrb_back #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned DRAIN_MAX  = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pcrb_pkg::cmd_t       cmd,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  pcrb_rsp_if.source                rsp,
  output pcrb_pkg::back_status_t    status
);
  import pcrb_pkg::*;

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(DRAIN_MAX + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FINAL = CNT_W'(DRAIN_MAX - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  state_t           state;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] cnt;
  logic             last_r;
  logic [REC_W-1:0] mem [RING_DEPTH];
  logic [REC_W-1:0] rdata;

  logic             out_valid;
  logic             out_level;
  logic [DUR_W-1:0] out_duration;
  logic             out_last;

  logic [PTR_W-1:0] rd_adv;
  logic [PTR_W-1:0] wr_adv;
  logic             pop;

  assign rd_adv    = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
  assign wr_adv    = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign cmd_ready = (state == S_IDLE);
  assign pop       = cmd_valid && cmd_ready;

  assign status.busy       = (state != S_IDLE);
  assign status.ring_empty = (rd_ptr == wr_ptr);

  assign rsp.valid         = out_valid;
  assign rsp.out_level     = out_level;
  assign rsp.out_duration  = out_duration;
  assign rsp.last_of_burst = out_last;

  // ring storage: one write port, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (pop && cmd.kind == CMD_CAPTURE) begin
      mem[wr_ptr] <= {cmd.level, cmd.duration};
    end
    rdata <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      last_r <= (rd_adv == wr_ptr) || (cnt == CNT_FINAL);
    end
    if (state == S_LOAD) begin
      out_level    <= rdata[REC_W-1];
      out_duration <= rdata[DUR_W-1:0];
      out_last     <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (cmd.kind)
              CMD_CAPTURE: begin
                // full ring: drop the oldest record
                if (wr_adv == rd_ptr) rd_ptr <= rd_adv;
                wr_ptr <= wr_adv;
              end
              CMD_DRAIN: begin
                cnt <= '0;
                if (rd_ptr != wr_ptr) state <= S_READ;
              end
              CMD_FLUSH: begin
                rd_ptr <= wr_ptr;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          rd_ptr <= rd_adv;
          cnt    <= cnt + 1'b1;
          state  <= S_LOAD;
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          state     <= S_SEND;
        end
        S_SEND: begin
          if (rsp.ready) begin
            out_valid <= 1'b0;
            state     <= out_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/pulse_capture_ring_buffer_core.sv
// Pulse capture ring buffer: top level joining front end, command queue and back end.
// Depends on pcrb_pkg, pcrb_if, pcrb_front and pcrb_back.
//
// Use:
//   req  - request channel (valid/ready). opcode 0 captures a pulse record
//          (pulse_level, pulse_duration; zero duration is dropped, longer than
//          16 bits saturates), 1 drains up to DRAIN_MAX oldest records, 2 flushes
//          every pending record, 3 does nothing.
//   rsp  - result channel (valid/ready), one record per beat, last_of_burst set
//          on the final record of a drain. A drain of an empty ring gives nothing.
//   The ring keeps at most RING_DEPTH-1 records; capturing into a full ring
//   drops the oldest one.
// Timing:
//   The front end takes a request every cycle while its 2-entry command queue
//   has room. The back end handles a capture or flush in its idle state. A drain
//   shows its first record after the command queue, the memory read and the
//   result register, then reads each further record only after the one before
//   it is taken on rsp, stepping through the read, load and send states.
// Reset (rst, synchronous): ring empty, queue empty, no result pending. Ring
//   contents are not cleared. When rsp stalls, the result register holds and
//   the back end waits; requests keep queuing until the queue is full.
`default_nettype none

module pulse_capture_ring_buffer_core #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned DRAIN_MAX  = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pcrb_req_if.sink    req,
  pcrb_rsp_if.source  rsp
);
  import pcrb_pkg::*;

  cmd_t         cmd;
  logic         cmd_valid;
  logic         cmd_ready;
  back_status_t status;

  pcrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  pcrb_back #(
    .RING_DEPTH (RING_DEPTH),
    .DRAIN_MAX  (DRAIN_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp       (rsp),
    .status    (status)
  );

  // results only appear while a drain is in progress
  a_rsp_in_drain: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> status.busy)
    else $error("result valid outside a drain");

  // a record that is not the last one keeps the drain running
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && !rsp.last_of_burst) |=> status.busy)
    else $error("drain ended without last_of_burst");

  // a flush leaves the ring empty
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.kind == CMD_FLUSH) |=> status.ring_empty)
    else $error("ring not empty after flush");

  // commands are only handed over while the back end is idle
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> !status.busy)
    else $error("command taken while back end busy");

endmodule

`default_nettype wire
